[sv/smma_pkg.sv]
// shared types, constants and codes of the scaled matrix multiply-accumulate block
package smma_pkg;

    localparam int VAL_W       = 32;
    localparam int FRAC_W      = 16;
    localparam int IDX_W       = 3;
    localparam int DIM_W       = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int MAX_DIM_DEF = 8;
    localparam int CMD_DEPTH   = 4;
    localparam int RES_DEPTH   = 2;

    localparam logic [DIM_W-1:0]        DIM_RESET   = DIM_W'(8);
    localparam logic signed [VAL_W-1:0] ALPHA_RESET = 32'sh0001_0000;
    localparam logic signed [VAL_W-1:0] BETA_RESET  = 32'sh0000_0000;
    localparam logic signed [VAL_W-1:0] Q_MAX       = 32'sh7fff_ffff;
    localparam logic signed [VAL_W-1:0] Q_MIN       = 32'sh8000_0000;

    typedef enum logic [1:0] {
        REQ_LOAD_A  = 2'd0,
        REQ_LOAD_B  = 2'd1,
        REQ_LOAD_C  = 2'd2,
        REQ_COMPUTE = 2'd3
    } req_e_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_M     = 3'd0,
        CFG_COLS_N     = 3'd1,
        CFG_INNER_K    = 3'd2,
        CFG_ALPHA_GAIN = 3'd3,
        CFG_BETA_GAIN  = 3'd4
    } cfg_idx_e_t;

    typedef struct packed {
        req_e_t                    req_type;
        logic [IDX_W-1:0]          row_index;
        logic [IDX_W-1:0]          col_index;
        logic signed [VAL_W-1:0]   element_value;
    } in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0]   result_value;
        logic [IDX_W-1:0]          result_row;
        logic [IDX_W-1:0]          result_col;
        logic                      last_result;
    } out_t;

    typedef struct packed {
        req_e_t                    op;
        logic [IDX_W-1:0]          row;
        logic [IDX_W-1:0]          col;
        logic signed [VAL_W-1:0]   value;
    } cmd_t;

    typedef struct packed {
        logic                      valid;
        cmd_t                      cmd;
    } cmd_wr_t;

    typedef struct packed {
        logic [DIM_W-1:0]          rows_m;
        logic [DIM_W-1:0]          cols_n;
        logic [DIM_W-1:0]          inner_k;
        logic signed [VAL_W-1:0]   alpha_gain;
        logic signed [VAL_W-1:0]   beta_gain;
    } cfg_t;

endpackage

[sv/smma_fifo.sv]
// small first-in first-out queue of packed items
module smma_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  T     wr_data,
    output logic full,
    input  logic rd_en,
    output T     rd_data,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    T                 mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[sv/smma_front.sv]
// request decode: range check of loads and command queue entry
module smma_front #(
    parameter int MAX_DIM = smma_pkg::MAX_DIM_DEF
) (
    input  logic              push,
    output logic              full,
    input  smma_pkg::in_t     request,
    input  logic              q_full,
    output smma_pkg::cmd_wr_t q_wr
);

    localparam int CMP_W = smma_pkg::IDX_W + 1;

    logic in_range;
    logic is_compute;

    // loads outside the stores are taken and dropped
    assign in_range   = ({1'b0, request.row_index} < CMP_W'(MAX_DIM))
                     && ({1'b0, request.col_index} < CMP_W'(MAX_DIM));
    assign is_compute = (request.req_type == smma_pkg::REQ_COMPUTE);

    assign full           = q_full;
    assign q_wr.valid     = push && !q_full && (is_compute || in_range);
    assign q_wr.cmd.op    = request.req_type;
    assign q_wr.cmd.row   = request.row_index;
    assign q_wr.cmd.col   = request.col_index;
    assign q_wr.cmd.value = request.element_value;

endmodule

[sv/smma_back.sv]
// element stores, compute sequencer and shared multiply datapath
module smma_back #(
    parameter int MAX_DIM = smma_pkg::MAX_DIM_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_empty,
    input  smma_pkg::cmd_t  cmd,
    output logic            cmd_pop,
    input  smma_pkg::cfg_t  cfg,
    input  logic            res_full,
    output logic            res_push,
    output smma_pkg::out_t  res
);

    localparam int VAL_W  = smma_pkg::VAL_W;
    localparam int FRAC_W = smma_pkg::FRAC_W;
    localparam int DIM_W  = smma_pkg::DIM_W;
    localparam int IDX_W  = smma_pkg::IDX_W;
    localparam int CNT_W  = $clog2(MAX_DIM);
    localparam int DCW    = CNT_W + 1;
    localparam int CELLS  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int TERM_W = 2 * VAL_W - FRAC_W;
    localparam int ACC_W  = TERM_W + CNT_W;
    localparam int HI_W   = ACC_W - VAL_W;
    localparam int MUL_W  = VAL_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int FULL_W = VAL_W + ACC_W;
    localparam int SCL_W  = FULL_W - FRAC_W;
    localparam int SUM_W  = SCL_W + 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MAC   = 7'b0000010,
        S_BETA  = 7'b0000100,
        S_ALO   = 7'b0001000,
        S_AHI   = 7'b0010000,
        S_SCALE = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [DCW-1:0]   iss_reg, iss_next;
    logic [DCW-1:0]   m_reg, m_next;
    logic [DCW-1:0]   n_reg, n_next;
    logic [DCW-1:0]   k_reg, k_next;
    logic             rd_vld_reg, rd_vld_next;
    logic             prod_vld_reg, prod_vld_next;

    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [PROD_W-1:0] plo_reg, plo_next;
    logic signed [TERM_W-1:0] beta_term_reg, beta_term_next;
    logic signed [SCL_W-1:0]  scaled_reg, scaled_next;

    logic signed [VAL_W-1:0] a_mem [CELLS];
    logic signed [VAL_W-1:0] b_mem [CELLS];
    logic signed [VAL_W-1:0] c_mem [CELLS];
    logic signed [VAL_W-1:0] a_rd_reg, b_rd_reg, c_rd_reg;

    logic [ADDR_W-1:0] ld_addr, a_raddr, b_raddr, ij_addr, c_waddr;
    logic [CNT_W-1:0]  r_idx;
    logic              a_we, b_we, c_we, a_re, b_re, c_re;
    logic signed [VAL_W-1:0] c_wdata;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [FULL_W-1:0] full_prod;
    logic signed [SUM_W-1:0]  sum;
    logic [SUM_W-VAL_W:0]     sum_top;
    logic                     ovf;
    logic signed [VAL_W-1:0]  sat_value;
    logic                     last_i, last_j;
    logic [DCW-1:0]           m_clamp, n_clamp, k_clamp;

    // dimension registers: zero acts as one, above the store size acts as full size
    function automatic logic [DCW-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DCW-1:0] v;
        if (d == '0)
        begin
            v = DCW'(1);
        end
        else if (d > DIM_W'(MAX_DIM))
        begin
            v = DCW'(MAX_DIM);
        end
        else
        begin
            v = DCW'(d);
        end
        return v;
    endfunction

    assign m_clamp = clamp_dim(cfg.rows_m);
    assign n_clamp = clamp_dim(cfg.cols_n);
    assign k_clamp = clamp_dim(cfg.inner_k);

    assign r_idx   = iss_reg[CNT_W-1:0];
    assign ld_addr = ADDR_W'(cmd.row) * ADDR_W'(MAX_DIM) + ADDR_W'(cmd.col);
    assign a_raddr = ADDR_W'(i_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(r_idx);
    assign b_raddr = ADDR_W'(r_idx) * ADDR_W'(MAX_DIM) + ADDR_W'(j_reg);
    assign ij_addr = ADDR_W'(i_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(j_reg);

    assign last_i = (DCW'(i_reg) + 1'b1 == m_reg);
    assign last_j = (DCW'(j_reg) + 1'b1 == n_reg);

    // alpha times the sum, rebuilt from the high and low partial products
    assign full_prod = $signed({prod_reg[ACC_W-1:0], {VAL_W{1'b0}}}) + FULL_W'(plo_reg);

    assign sum       = SUM_W'(scaled_reg) + SUM_W'(beta_term_reg);
    assign sum_top   = sum[SUM_W-1:VAL_W-1];
    assign ovf       = !((&sum_top) || !(|sum_top));
    assign sat_value = ovf ? (sum[SUM_W-1] ? smma_pkg::Q_MIN : smma_pkg::Q_MAX)
                           : sum[VAL_W-1:0];

    assign res.result_value = sat_value;
    assign res.result_row   = IDX_W'(i_reg);
    assign res.result_col   = IDX_W'(j_reg);
    assign res.last_result  = last_i && last_j;

    assign prod_next = mul_a * mul_b;

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        iss_next       = iss_reg;
        m_next         = m_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        rd_vld_next    = 1'b0;
        prod_vld_next  = 1'b0;
        acc_next       = acc_reg;
        plo_next       = plo_reg;
        beta_term_next = beta_term_reg;
        scaled_next    = scaled_reg;
        cmd_pop        = 1'b0;
        res_push       = 1'b0;
        a_we           = 1'b0;
        b_we           = 1'b0;
        c_we           = 1'b0;
        a_re           = 1'b0;
        b_re           = 1'b0;
        c_re           = 1'b0;
        c_waddr        = ld_addr;
        c_wdata        = cmd.value;
        mul_a          = MUL_W'(a_rd_reg);
        mul_b          = MUL_W'(b_rd_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op)
                        smma_pkg::REQ_LOAD_A: a_we = 1'b1;
                        smma_pkg::REQ_LOAD_B: b_we = 1'b1;
                        smma_pkg::REQ_LOAD_C: c_we = 1'b1;
                        smma_pkg::REQ_COMPUTE:
                        begin
                            m_next     = m_clamp;
                            n_next     = n_clamp;
                            k_next     = k_clamp;
                            i_next     = '0;
                            j_next     = '0;
                            iss_next   = '0;
                            acc_next   = '0;
                            state_next = S_MAC;
                        end
                        default: ;
                    endcase
                end
            end
            S_MAC:
            begin
                // read, multiply, accumulate: one inner step enters each cycle
                if (iss_reg < k_reg)
                begin
                    a_re        = 1'b1;
                    b_re        = 1'b1;
                    iss_next    = iss_reg + 1'b1;
                    rd_vld_next = 1'b1;
                end
                if (iss_reg == '0)
                begin
                    c_re = 1'b1;
                end
                prod_vld_next = rd_vld_reg;
                if (prod_vld_reg)
                begin
                    acc_next = acc_reg
                             + ACC_W'($signed(prod_reg[2*VAL_W-1:FRAC_W]));
                end
                if (!(iss_reg < k_reg) && !rd_vld_reg && !prod_vld_reg)
                begin
                    state_next = S_BETA;
                end
            end
            S_BETA:
            begin
                mul_a      = MUL_W'(cfg.beta_gain);
                mul_b      = MUL_W'(c_rd_reg);
                state_next = S_ALO;
            end
            S_ALO:
            begin
                mul_a          = MUL_W'(cfg.alpha_gain);
                mul_b          = $signed({1'b0, acc_reg[VAL_W-1:0]});
                beta_term_next = $signed(prod_reg[2*VAL_W-1:FRAC_W]);
                state_next     = S_AHI;
            end
            S_AHI:
            begin
                mul_a      = MUL_W'(cfg.alpha_gain);
                mul_b      = MUL_W'($signed(acc_reg[ACC_W-1:VAL_W]));
                plo_next   = prod_reg;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                scaled_next = full_prod[FULL_W-1:FRAC_W];
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (!res_full)
                begin
                    res_push = 1'b1;
                    c_we     = 1'b1;
                    c_waddr  = ij_addr;
                    c_wdata  = sat_value;
                    iss_next = '0;
                    acc_next = '0;
                    if (last_j)
                    begin
                        j_next = '0;
                        if (last_i)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            i_next     = i_reg + 1'b1;
                            state_next = S_MAC;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_MAC;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            i_reg        <= '0;
            j_reg        <= '0;
            iss_reg      <= '0;
            m_reg        <= DCW'(1);
            n_reg        <= DCW'(1);
            k_reg        <= DCW'(1);
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            iss_reg      <= iss_next;
            m_reg        <= m_next;
            n_reg        <= n_next;
            k_reg        <= k_next;
            rd_vld_reg   <= rd_vld_next;
            prod_vld_reg <= prod_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        prod_reg      <= prod_next;
        plo_reg       <= plo_next;
        beta_term_reg <= beta_term_next;
        scaled_reg    <= scaled_next;
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            a_mem[ld_addr] <= cmd.value;
        end
        if (a_re)
        begin
            a_rd_reg <= a_mem[a_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            b_mem[ld_addr] <= cmd.value;
        end
        if (b_re)
        begin
            b_rd_reg <= b_mem[b_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            c_mem[c_waddr] <= c_wdata;
        end
        if (c_re)
        begin
            c_rd_reg <= c_mem[ij_addr];
        end
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> ((DCW'(i_reg) < m_reg) && (DCW'(j_reg) < n_reg)))
        else $error("element index beyond the active dimensions");

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC) |-> (iss_reg <= k_reg))
        else $error("inner step count ran past inner_k");

    a_pipe_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BETA) |-> (!rd_vld_reg && !prod_vld_reg))
        else $error("scaling started with products still in flight");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.last_result) |=> (state_reg == S_IDLE))
        else $error("sequencer kept running after the final element");

endmodule

[sv/scaled_matrix_multiply_accumulate.sv]
// top level of the scaled matrix multiply-accumulate block, C = beta*C + alpha*A*B
//
// usage
//   request channel (push/full): a request is taken at a clock edge with push high and
//   full low; load A, load B and load C write one Q16.16 element, compute runs the
//   whole C = beta*C + alpha*A*B over rows_m x cols_n x inner_k
//   result channel (empty/pop): while empty is low the oldest result is on result, it
//   leaves at an edge with pop high; one result per C element in row-major order,
//   last_result marks the final one; loads give no result
//   config port: cfg_write with cfg_index and cfg_data, written at the clock edge; the user
//   writes only while the block is idle, the block itself does not enforce this
//   throughput: loads go through at one per cycle while the back end is idle; a compute
//   is paced by the single shared multiplier that does the inner products and then
//   the beta and two alpha partial products per element
//   command path: a taken request is written into a four-entry command queue, from
//   which the back end reads it while idle
//   stall: when result is not popped the two-entry result queue fills and the back end
//   holds; requests keep queueing until the command queue is full
//   reset: queues empty, dimension registers 8, alpha 1.0, beta 0; the element stores
//   hold nothing meaningful until loaded
module scaled_matrix_multiply_accumulate #(
    parameter int MAX_DIM = smma_pkg::MAX_DIM_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  smma_pkg::in_t                     request,
    output logic                              empty,
    input  logic                              pop,
    output smma_pkg::out_t                    result,
    input  logic                              cfg_write,
    input  logic [smma_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [smma_pkg::VAL_W-1:0]        cfg_data
);

    // configuration registers
    logic [smma_pkg::DIM_W-1:0]        rows_m_reg, rows_m_next;
    logic [smma_pkg::DIM_W-1:0]        cols_n_reg, cols_n_next;
    logic [smma_pkg::DIM_W-1:0]        inner_k_reg, inner_k_next;
    logic signed [smma_pkg::VAL_W-1:0] alpha_reg, alpha_next;
    logic signed [smma_pkg::VAL_W-1:0] beta_reg, beta_next;
    smma_pkg::cfg_t                    cfg;

    // front to command queue to back end
    smma_pkg::cmd_wr_t q_wr;
    logic              q_full;
    logic              cmd_empty;
    logic              cmd_pop;
    smma_pkg::cmd_t    cmd;

    // back end to result queue
    logic              res_full;
    logic              res_push;
    smma_pkg::out_t    res;

    always_comb
    begin
        rows_m_next  = rows_m_reg;
        cols_n_next  = cols_n_reg;
        inner_k_next = inner_k_reg;
        alpha_next   = alpha_reg;
        beta_next    = beta_reg;
        if (cfg_write)
        begin
            // indexes past the register list are ignored
            unique case (cfg_index)
                smma_pkg::CFG_ROWS_M:     rows_m_next  = cfg_data[smma_pkg::DIM_W-1:0];
                smma_pkg::CFG_COLS_N:     cols_n_next  = cfg_data[smma_pkg::DIM_W-1:0];
                smma_pkg::CFG_INNER_K:    inner_k_next = cfg_data[smma_pkg::DIM_W-1:0];
                smma_pkg::CFG_ALPHA_GAIN: alpha_next   = $signed(cfg_data);
                smma_pkg::CFG_BETA_GAIN:  beta_next    = $signed(cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_m_reg  <= smma_pkg::DIM_RESET;
            cols_n_reg  <= smma_pkg::DIM_RESET;
            inner_k_reg <= smma_pkg::DIM_RESET;
            alpha_reg   <= smma_pkg::ALPHA_RESET;
            beta_reg    <= smma_pkg::BETA_RESET;
        end
        else
        begin
            rows_m_reg  <= rows_m_next;
            cols_n_reg  <= cols_n_next;
            inner_k_reg <= inner_k_next;
            alpha_reg   <= alpha_next;
            beta_reg    <= beta_next;
        end
    end

    assign cfg.rows_m     = rows_m_reg;
    assign cfg.cols_n     = cols_n_reg;
    assign cfg.inner_k    = inner_k_reg;
    assign cfg.alpha_gain = alpha_reg;
    assign cfg.beta_gain  = beta_reg;

    // decode and range check of incoming requests
    smma_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .push    (push),
        .full    (full),
        .request (request),
        .q_full  (q_full),
        .q_wr    (q_wr)
    );

    // decouples request intake from the compute sequencer
    smma_fifo #(
        .T     (smma_pkg::cmd_t),
        .DEPTH (smma_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr.valid),
        .wr_data (q_wr.cmd),
        .full    (q_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd),
        .empty   (cmd_empty)
    );

    // stores, sequencer and multiply datapath
    smma_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .cfg       (cfg),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    // results wait here while the receiver stalls
    smma_fifo #(
        .T     (smma_pkg::out_t),
        .DEPTH (smma_pkg::RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule

[tb/sv/tb.sv]
// self-checking testbench for the scaled matrix multiply-accumulate block
`timescale 1ns / 1ps

module tb;
    import smma_pkg::*;

    // block geometry, as instantiated with its default size
    localparam int DIM = MAX_DIM_DEF;

    // run shape
    localparam int RESET_CYCLES   = 8;
    localparam int ITEM_TARGET    = 380;   // directed rows plus about 360 random requests
    localparam int SETTLE_CYCLES  = 16;    // queued loads still draining after the last result
    localparam int DRAIN_CYCLES   = 50;
    localparam int HOLD_CYCLES    = 400;   // the one long receiver hold-off
    localparam int HOLD_JOB       = 6;     // random job during which that hold-off happens
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no request and no result moving
    localparam int MAX_REPORTS    = 40;

    // register index with no register behind it, writes to it change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd5;

    // q16.16 spans of the small random values
    localparam int unsigned GAIN_SPAN  = 32'h0002_0000;   // +-2.0
    localparam int unsigned VALUE_SPAN = 32'h0004_0000;   // +-4.0

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    in_t                   request;
    logic                  empty;
    logic                  pop;
    out_t                  result;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [VAL_W-1:0]      cfg_data;

    scaled_matrix_multiply_accumulate uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // one row of the directed table: either a register write or a request,
    // with a hand-worked result value where one can be read off directly
    typedef struct {
        bit                       is_cfg;
        logic [CFG_IDX_W-1:0]     reg_idx;
        logic [VAL_W-1:0]         reg_data;
        in_t                      req;
        bit                       known;
        logic signed [VAL_W-1:0]  known_val;
    } dir_row_t;

    // ------------------------------------------------------------------
    // shadow copy of the block: element stores, written flags, registers
    // ------------------------------------------------------------------
    logic signed [VAL_W-1:0] a_mem [DIM*DIM];
    logic signed [VAL_W-1:0] b_mem [DIM*DIM];
    logic signed [VAL_W-1:0] c_mem [DIM*DIM];
    bit                      a_loaded [DIM*DIM];
    bit                      b_loaded [DIM*DIM];
    bit                      c_loaded [DIM*DIM];

    logic [DIM_W-1:0]        m_reg     = DIM_RESET;
    logic [DIM_W-1:0]        n_reg     = DIM_RESET;
    logic [DIM_W-1:0]        k_reg     = DIM_RESET;
    logic signed [VAL_W-1:0] alpha_reg = ALPHA_RESET;
    logic signed [VAL_W-1:0] beta_reg  = BETA_RESET;

    // new c elements still owed by the block, oldest first
    out_t c_elements_due [$];

    // bookkeeping
    int  errors          = 0;
    int  reqs_sent       = 0;
    int  computes_sent   = 0;
    int  results_checked = 0;
    int  settings_done   = 0;
    int  burst_left      = 0;
    bit  cfg_open        = 0;
    bit  hold_pop        = 0;

    // free-running clock, 10 ns period
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // arithmetic of the block
    // ------------------------------------------------------------------

    // floor(g * x / 2^16), magnitude capped at 2^56 for the huge scaled sum
    function automatic longint q_mul(input longint g, input longint x);
        bit               neg;
        longint unsigned  ug;
        longint unsigned  ux;
        longint unsigned  ah;
        longint unsigned  al;
        longint unsigned  q;
        longint unsigned  rem;
        neg = (g < 0) != (x < 0);
        ug  = (g < 0) ? -g : g;
        ux  = (x < 0) ? -x : x;
        ah  = ug * (ux >> 32);
        al  = ug * (ux & 64'hFFFF_FFFF);
        if (ah >= (64'd1 << 40))
        begin
            q   = 64'd1 << 56;
            rem = 0;
        end
        else
        begin
            q   = (ah << 16) + (al >> 16);
            rem = al & 64'hFFFF;
        end
        if (neg)
            return -longint'(q + ((rem != 0) ? 64'd1 : 64'd0));
        return longint'(q);
    endfunction

    // a dimension of zero works as one, any above the store size as the store size
    function automatic int dim_used(input logic [DIM_W-1:0] d);
        if (d < 1)
            return 1;
        if (d > DIM)
            return DIM;
        return int'(d);
    endfunction

    // loads fill one store entry; a compute owes rows x cols new c elements,
    // each also written back into the c store
    function automatic void apply_gemm_request(input in_t req);
        int      mm;
        int      nn;
        int      kk;
        int      pos;
        longint  acc;
        longint  res;
        out_t    elem;
        if (req.req_type != REQ_COMPUTE)
        begin
            if (req.row_index >= DIM || req.col_index >= DIM)
                return;
            pos = int'(req.row_index) * DIM + int'(req.col_index);
            case (req.req_type)
                REQ_LOAD_A:
                begin
                    a_mem[pos]    = req.element_value;
                    a_loaded[pos] = 1'b1;
                end
                REQ_LOAD_B:
                begin
                    b_mem[pos]    = req.element_value;
                    b_loaded[pos] = 1'b1;
                end
                default:
                begin
                    c_mem[pos]    = req.element_value;
                    c_loaded[pos] = 1'b1;
                end
            endcase
            return;
        end
        mm = dim_used(m_reg);
        nn = dim_used(n_reg);
        kk = dim_used(k_reg);
        for (int i = 0; i < mm; i++)
        begin
            for (int j = 0; j < nn; j++)
            begin
                acc = 0;
                for (int r = 0; r < kk; r++)
                    acc += q_mul(longint'(a_mem[i*DIM + r]), longint'(b_mem[r*DIM + j]));
                pos = i * DIM + j;
                res = q_mul(longint'(beta_reg), longint'(c_mem[pos]))
                    + q_mul(longint'(alpha_reg), acc);
                if (res > longint'(Q_MAX))
                    res = longint'(Q_MAX);
                if (res < longint'(Q_MIN))
                    res = longint'(Q_MIN);
                c_mem[pos]        = res[VAL_W-1:0];
                elem.result_value = res[VAL_W-1:0];
                elem.result_row   = IDX_W'(i);
                elem.result_col   = IDX_W'(j);
                elem.last_result  = (i == mm - 1) && (j == nn - 1);
                c_elements_due.push_back(elem);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // random choices
    // ------------------------------------------------------------------

    // mostly small matrices, now and then zero, the full size or beyond it
    function automatic logic [DIM_W-1:0] pick_dim();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return DIM_W'($urandom_range(DIM + 1, 15));
        if (roll == 2)
            return DIM_W'(DIM);
        return DIM_W'($urandom_range(1, 3));
    endfunction

    // q16.16 value: extremes, one, any 32-bit pattern, or small around zero
    function automatic logic signed [VAL_W-1:0] pick_q(input int unsigned span);
        case ($urandom_range(0, 7))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return ALPHA_RESET;
            4:       return $urandom;
            default: return $urandom_range(0, 2 * span) - span;
        endcase
    endfunction

    // load with random target and content, any entry of any store
    function automatic in_t random_load();
        in_t req;
        req.req_type      = req_e_t'($urandom_range(REQ_LOAD_A, REQ_LOAD_C));
        req.row_index     = IDX_W'($urandom_range(0, DIM - 1));
        req.col_index     = IDX_W'($urandom_range(0, DIM - 1));
        req.element_value = pick_q(VALUE_SPAN);
        return req;
    endfunction

    function automatic in_t make_load(input req_e_t op, input int row, input int col);
        in_t req;
        req.req_type      = op;
        req.row_index     = IDX_W'(row);
        req.col_index     = IDX_W'(col);
        req.element_value = pick_q(VALUE_SPAN);
        return req;
    endfunction

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------

    // stop offering requests and wait until the block has nothing left to do
    task automatic wait_idle();
        push       <= 1'b0;
        burst_left  = 0;
        while (c_elements_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write; the first of a group waits for the block to go idle
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        if (!cfg_open)
            wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_open = 1'b1;
        case (idx)
            CFG_ROWS_M:     m_reg     = data[DIM_W-1:0];
            CFG_COLS_N:     n_reg     = data[DIM_W-1:0];
            CFG_INNER_K:    k_reg     = data[DIM_W-1:0];
            CFG_ALPHA_GAIN: alpha_reg = data;
            CFG_BETA_GAIN:  beta_reg  = data;
            default:        ;
        endcase
    endtask

    // one request through the push/full handshake, sender in bursts with gaps;
    // a known value replaces the predicted one of a single-element compute
    task automatic send_request(input in_t req, input bit known,
                                input logic signed [VAL_W-1:0] known_val);
        out_t elem;
        if (cfg_open)
        begin
            cfg_write <= 1'b0;
            cfg_open   = 1'b0;
        end
        if (burst_left == 0)
        begin
            // gap: push low, junk on the request bus
            push    <= 1'b0;
            request <= in_t'({$urandom, $urandom});
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        push    <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (full);
        // taken at this edge
        apply_gemm_request(req);
        if (known)
        begin
            elem              = c_elements_due.pop_back();
            elem.result_value = known_val;
            c_elements_due.push_back(elem);
        end
        reqs_sent++;
        if (req.req_type == REQ_COMPUTE)
            computes_sent++;
    endtask

    // new register setting: all five registers, extra upper data bits on the
    // dimension writes, sometimes a write to an unused index
    task automatic new_setting(input bit squeeze);
        logic [VAL_W-1:0] data;
        data = $urandom;
        data[DIM_W-1:0] = squeeze ? DIM_W'(3) : pick_dim();
        set_reg(CFG_ROWS_M, data);
        data = $urandom;
        data[DIM_W-1:0] = squeeze ? DIM_W'(3) : pick_dim();
        set_reg(CFG_COLS_N, data);
        data = $urandom;
        data[DIM_W-1:0] = squeeze ? DIM_W'(2) : pick_dim();
        set_reg(CFG_INNER_K, data);
        set_reg(CFG_ALPHA_GAIN, pick_q(GAIN_SPAN));
        set_reg(CFG_BETA_GAIN, pick_q(GAIN_SPAN));
        if ($urandom_range(0, 5) == 0)
            set_reg(CFG_IDX_W'($urandom_range(CFG_SPARE, 7)), $urandom);
        settings_done++;
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        dir_row_t steps [$];
        int       mm;
        int       nn;
        int       kk;
        int       job;

        // directed table: 1x1 products first so the answers are plain to see
        //            cfg   index           data
        //                  request                                            known value
        steps = '{
            '{1'b1, CFG_ROWS_M,     32'd1,         '0,                                  1'b0, '0},
            '{1'b1, CFG_COLS_N,     32'd1,         '0,                                  1'b0, '0},
            '{1'b1, CFG_INNER_K,    32'd1,         '0,                                  1'b0, '0},
            '{1'b1, CFG_SPARE,      32'h5a5a_a5a5, '0,                                  1'b0, '0},
            // 1.0 * 2.0 with beta 0, old c ignored
            '{1'b0, '0, '0, '{REQ_LOAD_A,  3'd0, 3'd0, 32'sh0001_0000},                 1'b0, '0},
            '{1'b0, '0, '0, '{REQ_LOAD_B,  3'd0, 3'd0, 32'sh0002_0000},                 1'b0, '0},
            '{1'b0, '0, '0, '{REQ_LOAD_C,  3'd0, 3'd0, 32'sh0012_3456},                 1'b0, '0},
            '{1'b0, '0, '0, '{REQ_COMPUTE, 3'd7, 3'd7, Q_MIN},             1'b1, 32'sh0002_0000},
            // largest squared saturates high, smallest times largest saturates low
            '{1'b0, '0, '0, '{REQ_LOAD_A,  3'd0, 3'd0, Q_MAX},                          1'b0, '0},
            '{1'b0, '0, '0, '{REQ_LOAD_B,  3'd0, 3'd0, Q_MAX},                          1'b0, '0},
            '{1'b0, '0, '0, '{REQ_COMPUTE, 3'd0, 3'd0, 32'sh0000_0000},                 1'b1, Q_MAX},
            '{1'b0, '0, '0, '{REQ_LOAD_A,  3'd0, 3'd0, Q_MIN},                          1'b0, '0},
            '{1'b0, '0, '0, '{REQ_COMPUTE, 3'd3, 3'd5, Q_MAX},                          1'b1, Q_MIN},
            // alpha 0, beta 1.0: the old c passes through
            '{1'b1, CFG_ALPHA_GAIN, 32'h0000_0000, '0,                                  1'b0, '0},
            '{1'b1, CFG_BETA_GAIN,  32'h0001_0000, '0,                                  1'b0, '0},
            '{1'b0, '0, '0, '{REQ_LOAD_C,  3'd0, 3'd0, 32'sh0003_0000},                 1'b0, '0},
            '{1'b0, '0, '0, '{REQ_COMPUTE, 3'd0, 3'd0, 32'sh0000_0000},    1'b1, 32'sh0003_0000},
            // extreme gains: scaled sum hits its clamp, result pinned low
            '{1'b1, CFG_ALPHA_GAIN, Q_MAX,         '0,                                  1'b0, '0},
            '{1'b1, CFG_BETA_GAIN,  Q_MIN,         '0,                                  1'b0, '0},
            '{1'b0, '0, '0, '{REQ_COMPUTE, 3'd0, 3'd0, 32'sh0000_0000},                 1'b1, Q_MIN},
            // far corner of every store
            '{1'b0, '0, '0, '{REQ_LOAD_A,  3'd7, 3'd7, Q_MAX},                          1'b0, '0},
            '{1'b0, '0, '0, '{REQ_LOAD_B,  3'd7, 3'd7, Q_MIN},                          1'b0, '0},
            '{1'b0, '0, '0, '{REQ_LOAD_C,  3'd7, 3'd7, 32'sh0000_0000},                 1'b0, '0},
            // zero dimensions work as one
            '{1'b1, CFG_ROWS_M,     32'hf000_0000, '0,                                  1'b0, '0},
            '{1'b1, CFG_INNER_K,    32'h0000_0000, '0,                                  1'b0, '0},
            '{1'b1, CFG_ALPHA_GAIN, 32'hffff_0000, '0,                                  1'b0, '0},
            '{1'b1, CFG_BETA_GAIN,  32'h0000_8000, '0,                                  1'b0, '0},
            '{1'b0, '0, '0, '{REQ_COMPUTE, 3'd1, 3'd2, 32'sh7654_3210},                 1'b0, '0}
        };

        push      <= 1'b0;
        request   <= '0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n     <= 1'b1;

        foreach (steps[s])
        begin
            if (steps[s].is_cfg)
                set_reg(steps[s].reg_idx, steps[s].reg_data);
            else
                send_request(steps[s].req, steps[s].known, steps[s].known_val);
        end

        // random jobs: random loads, then whatever the next compute still needs
        // loaded plus some reloads, then the compute, sometimes two in a row
        job = 0;
        while (reqs_sent < ITEM_TARGET)
        begin
            if (job == HOLD_JOB)
                new_setting(1'b1);      // enough elements to back the block up
            else if (job == 0 || (job != HOLD_JOB + 1 && $urandom_range(0, 2) == 0))
                new_setting(1'b0);
            mm = dim_used(m_reg);
            nn = dim_used(n_reg);
            kk = dim_used(k_reg);
            repeat ($urandom_range(0, 5))
                send_request(random_load(), 1'b0, '0);
            for (int i = 0; i < mm; i++)
                for (int r = 0; r < kk; r++)
                    if (!a_loaded[i*DIM + r] || $urandom_range(0, 3) == 0)
                        send_request(make_load(REQ_LOAD_A, i, r), 1'b0, '0);
            for (int r = 0; r < kk; r++)
                for (int j = 0; j < nn; j++)
                    if (!b_loaded[r*DIM + j] || $urandom_range(0, 3) == 0)
                        send_request(make_load(REQ_LOAD_B, r, j), 1'b0, '0);
            for (int i = 0; i < mm; i++)
                for (int j = 0; j < nn; j++)
                    if (!c_loaded[i*DIM + j] || $urandom_range(0, 3) == 0)
                        send_request(make_load(REQ_LOAD_C, i, j), 1'b0, '0);
            // receiver goes quiet just before this compute, so its results
            // pile up and the loads behind it stall the request side
            if (job == HOLD_JOB)
                hold_pop = 1'b1;
            send_request(in_t'({REQ_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), $urandom}),
                         1'b0, '0);
            // a second compute reuses the written-back c
            if ($urandom_range(0, 4) == 0)
                send_request(in_t'({REQ_COMPUTE, IDX_W'($urandom), IDX_W'($urandom),
                                    $urandom}), 1'b0, '0);
            if (job == HOLD_JOB)
                repeat (8) send_request(random_load(), 1'b0, '0);
            job++;
        end

        // everything accepted: wait for the last element, then a quiet spell
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests (%0d computes) over %0d register settings and %0d jobs",
                 reqs_sent, computes_sent, settings_done, job);
        $display("%0d result elements checked, one receiver hold-off of %0d cycles",
                 results_checked, HOLD_CYCLES);
        if (errors == 0 && c_elements_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // receiver: random pop pattern that changes from span to span, one long hold-off
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int mode;
        int span;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 60);
            repeat (span)
            begin
                @(posedge clk);
                if (hold_pop)
                begin
                    hold_pop = 1'b0;
                    pop     <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                else
                begin
                    case (mode)
                        0:       pop <= 1'b1;                          // no stalls
                        1:       pop <= $urandom_range(0, 1);
                        2:       pop <= ($urandom_range(0, 4) == 0);   // mostly stalled
                        default: pop <= ($urandom_range(0, 7) != 0);
                    endcase
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result checking against the oldest owed element
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    endtask

    always @(posedge clk)
    begin : result_check
        out_t want;
        if (rst_n && pop && !empty)
        begin
            if (c_elements_due.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, got %0h", $time, result);
            end
            else
            begin
                want = c_elements_due.pop_front();
                if (result.result_value !== want.result_value)
                    note_mismatch("result_value", want.result_value, result.result_value);
                if (result.result_row !== want.result_row)
                    note_mismatch("result_row", want.result_row, result.result_row);
                if (result.result_col !== want.result_col)
                    note_mismatch("result_col", want.result_col, result.result_col);
                if (result.last_result !== want.last_result)
                    note_mismatch("last_result", want.last_result, result.last_result);
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long with neither a request nor a result moving
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: timeout, nothing moved for %0d cycles, %0d elements still owed",
                 $time, quiet, c_elements_due.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[filelist.f]
sv/smma_pkg.sv
sv/smma_fifo.sv
sv/smma_front.sv
sv/smma_back.sv
sv/scaled_matrix_multiply_accumulate.sv
tb/sv/tb.sv
